// ----- rtl/hca_pkg.sv -----
package hca_pkg;

  localparam int unsigned HUE_FULL = 92160;
  localparam int unsigned HUE_SEG  = 15360;
  localparam int unsigned ONE_Q12  = 4096;
  localparam int unsigned RECIP_15 = 279621;

  localparam logic [1:0] CFG_HUE = 2'd0;
  localparam logic [1:0] CFG_SAT = 2'd1;
  localparam logic [1:0] CFG_VAL = 2'd2;

  localparam int unsigned DEPTH = 8;

  typedef struct packed {
    logic [11:0] hue;
    logic [11:0] sat;
    logic [11:0] val;
  } gain_t;

  typedef struct packed {
    logic [28:0] hp;
    logic [24:0] sp;
    logic [24:0] vp;
  } prod_t;

  // ceil(2^22 / m), exact quotient by multiply and shift for small dividends
  function automatic logic [22:0] recip(input logic [3:0] m);
    logic [22:0] r;
    case (m)
      4'd1:    r = 23'd4194304;
      4'd2:    r = 23'd2097152;
      4'd3:    r = 23'd1398102;
      4'd4:    r = 23'd1048576;
      4'd5:    r = 23'd838861;
      4'd6:    r = 23'd699051;
      4'd7:    r = 23'd599187;
      4'd8:    r = 23'd524288;
      4'd9:    r = 23'd466034;
      4'd10:   r = 23'd419431;
      4'd11:   r = 23'd381301;
      4'd12:   r = 23'd349526;
      4'd13:   r = 23'd322639;
      4'd14:   r = 23'd299594;
      4'd15:   r = 23'd279621;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/hca_rgb2hsv.sv -----
module hca_rgb2hsv (
  input  logic                clk,
  input  logic                en,
  input  logic [3:0]          red,
  input  logic [3:0]          green,
  input  logic [3:0]          blue,
  input  hca_pkg::gain_t      gain,
  output hca_pkg::prod_t      prod
);

  logic [3:0]  r_r, g_r, b_r;
  logic [3:0]  mx, mn, d;
  logic signed [4:0] diff;
  logic [3:0]  a;
  logic [16:0] base;
  logic [26:0] sq;
  logic [30:0] hq;

  logic [12:0] s2_r, v2_r;
  logic [17:0] q2_r;
  logic [7:0]  y2_r;
  logic [3:0]  d2_r;
  logic        neg2_r;
  logic [16:0] base2_r;

  logic [21:0] qd;
  logic        inexact;
  logic [17:0] hh;
  logic [16:0] hw;

  logic [16:0] h3_r;
  logic [12:0] s3_r, v3_r;
  hca_pkg::prod_t prod_r;

  always_comb begin
    mx = (r_r > g_r) ? r_r : g_r;
    mn = (r_r < g_r) ? r_r : g_r;
    mx = (b_r > mx) ? b_r : mx;
    mn = (b_r < mn) ? b_r : mn;
    d  = mx - mn;
    if (mx == r_r) begin
      diff = $signed({1'b0, g_r}) - $signed({1'b0, b_r});
      base = 17'(hca_pkg::HUE_FULL);
    end else if (mx == g_r) begin
      diff = $signed({1'b0, b_r}) - $signed({1'b0, r_r});
      base = 17'(2 * hca_pkg::HUE_SEG);
    end else begin
      diff = $signed({1'b0, r_r}) - $signed({1'b0, g_r});
      base = 17'(4 * hca_pkg::HUE_SEG);
    end
    a  = diff[4] ? 4'(-diff) : diff[3:0];
    sq = 27'(d) * 27'(hca_pkg::recip(mx));
    hq = 31'(8'(a) * 8'd15) * 31'(hca_pkg::recip(d));
  end

  always_comb begin
    qd      = 22'(q2_r) * 22'(d2_r);
    inexact = (qd != 22'({y2_r, 10'd0}));
    if (neg2_r) begin
      hh = 18'(base2_r) - q2_r - 18'(inexact);
    end else begin
      hh = 18'(base2_r) + q2_r;
    end
    if (d2_r == 4'd0) begin
      hw = 17'd0;
    end else if (hh >= 18'(hca_pkg::HUE_FULL)) begin
      hw = 17'(hh - 18'(hca_pkg::HUE_FULL));
    end else begin
      hw = hh[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r     <= red;
      g_r     <= green;
      b_r     <= blue;
      s2_r    <= sq[22:10];
      v2_r    <= 13'((23'(mx) * 23'(hca_pkg::RECIP_15)) >> 10);
      q2_r    <= hq[29:12];
      y2_r    <= 8'(a) * 8'd15;
      d2_r    <= d;
      neg2_r  <= diff[4];
      base2_r <= base;
      h3_r    <= hw;
      s3_r    <= s2_r;
      v3_r    <= v2_r;
      prod_r.hp <= 29'(h3_r) * 29'(gain.hue);
      prod_r.sp <= 25'(s3_r) * 25'(gain.sat);
      prod_r.vp <= 25'(v3_r) * 25'(gain.val);
    end
  end

  assign prod = prod_r;

endmodule

// ----- rtl/hca_hsv2rgb.sv -----
module hca_hsv2rgb (
  input  logic           clk,
  input  logic           en,
  input  hca_pkg::prod_t prod,
  output logic [3:0]     red,
  output logic [3:0]     green,
  output logic [3:0]     blue
);

  logic [20:0] hg;
  logic [16:0] sg, vg;
  logic [16:0] h;
  logic [12:0] s;
  logic [2:0]  seg;
  logic [13:0] rem;

  logic [25:0] sr5_r;
  logic [12:0] s5_r;
  logic [16:0] v5_r;
  logic [2:0]  seg5_r;

  logic [34:0] sfp;
  logic [29:0] pp;
  logic [12:0] sf6_r, p6_r, s6_r;
  logic [16:0] v6_r;
  logic [2:0]  seg6_r;

  logic [30:0] qp, tp;
  logic [12:0] p7_r, q7_r, t7_r;
  logic [16:0] v7_r;
  logic [2:0]  seg7_r;

  logic [16:0] cr, cg, cb;
  logic [3:0]  red_r, green_r, blue_r;

  function automatic logic [12:0] clamp_one(input logic [18:0] x);
    return (x > 19'(hca_pkg::ONE_Q12)) ? 13'(hca_pkg::ONE_Q12) : x[12:0];
  endfunction

  function automatic logic [3:0] to_nibble(input logic [16:0] x);
    logic [21:0] c;
    c = (22'(x) * 22'd15 + 22'd64) >> 12;
    return (c > 22'd15) ? 4'd15 : c[3:0];
  endfunction

  always_comb begin
    hg = 21'(prod.hp >> 8);
    sg = 17'(prod.sp >> 8);
    vg = 17'(prod.vp >> 8);
    h  = (hg > 21'(hca_pkg::HUE_FULL)) ? 17'(hca_pkg::HUE_FULL) : hg[16:0];
    s  = (sg > 17'(hca_pkg::ONE_Q12)) ? 13'(hca_pkg::ONE_Q12) : sg[12:0];
    if (h >= 17'(6 * hca_pkg::HUE_SEG)) begin
      seg = 3'd6;
    end else if (h >= 17'(5 * hca_pkg::HUE_SEG)) begin
      seg = 3'd5;
    end else if (h >= 17'(4 * hca_pkg::HUE_SEG)) begin
      seg = 3'd4;
    end else if (h >= 17'(3 * hca_pkg::HUE_SEG)) begin
      seg = 3'd3;
    end else if (h >= 17'(2 * hca_pkg::HUE_SEG)) begin
      seg = 3'd2;
    end else if (h >= 17'(hca_pkg::HUE_SEG)) begin
      seg = 3'd1;
    end else begin
      seg = 3'd0;
    end
    rem = 14'(h - 17'(seg) * 17'(hca_pkg::HUE_SEG));
  end

  always_comb begin
    sfp = 35'(sr5_r[25:10]) * 35'(hca_pkg::RECIP_15);
    pp  = 30'(v5_r) * 30'(14'(hca_pkg::ONE_Q12) - 14'(s5_r));
    qp  = 31'(v6_r) * 31'(14'(hca_pkg::ONE_Q12) - 14'(sf6_r));
    tp  = 31'(v6_r) * 31'(14'(hca_pkg::ONE_Q12) - 14'(s6_r) + 14'(sf6_r));
  end

  always_comb begin
    case (seg7_r)
      3'd0: begin
        cr = v7_r;        cg = 17'(t7_r); cb = 17'(p7_r);
      end
      3'd1: begin
        cr = 17'(q7_r);   cg = v7_r;      cb = 17'(p7_r);
      end
      3'd2: begin
        cr = 17'(p7_r);   cg = v7_r;      cb = 17'(t7_r);
      end
      3'd3: begin
        cr = 17'(p7_r);   cg = 17'(q7_r); cb = v7_r;
      end
      3'd4: begin
        cr = 17'(t7_r);   cg = 17'(p7_r); cb = v7_r;
      end
      default: begin
        cr = v7_r;        cg = 17'(p7_r); cb = 17'(q7_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr5_r   <= 26'(s) * 26'(rem);
      s5_r    <= s;
      v5_r    <= vg;
      seg5_r  <= seg;
      sf6_r   <= 13'(sfp >> 22);
      p6_r    <= clamp_one(19'(pp >> 12));
      s6_r    <= s5_r;
      v6_r    <= v5_r;
      seg6_r  <= seg5_r;
      p7_r    <= p6_r;
      q7_r    <= clamp_one(19'(qp >> 12));
      t7_r    <= clamp_one(19'(tp >> 12));
      v7_r    <= v6_r;
      seg7_r  <= seg6_r;
      red_r   <= to_nibble(cr);
      green_r <= to_nibble(cg);
      blue_r  <= to_nibble(cb);
    end
  end

  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

// ----- rtl/hsv_color_adjust.sv -----
// Color adjustment in HSV space for two RGB444 pixels per 32-bit word: each
// pixel goes to hue/saturation/value, each is scaled by an unsigned Q4.8 gain
// (256 is unity, reset 256) and the pixel goes back to RGB444. One word is
// taken every clock cycle while the output is not stalled; the fixed-point
// pipeline has eight register stages. A stall on the output holds the whole
// pipeline. The user must write gains through cfg_ only while no pixel is in
// flight, which the block does not enforce: index 0 hue, 1 saturation, 2 value.
module hsv_color_adjust (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // raw_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // red_a, green_a, blue_a, red_b, green_b, blue_b from bit 0 up
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  logic                            en;
  logic [hca_pkg::DEPTH-1:0]       vld_r, vld_nxt;
  hca_pkg::gain_t                  gain_r, gain_nxt;
  hca_pkg::prod_t                  prod_a, prod_b;
  logic [3:0] red_a, green_a, blue_a, red_b, green_b, blue_b;

  assign en        = !vld_r[hca_pkg::DEPTH-1] || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_comb begin
    vld_nxt  = en ? {vld_r[hca_pkg::DEPTH-2:0], in_tvalid} : vld_r;
    gain_nxt = gain_r;
    if (cfg_valid) begin
      case (cfg_index)
        hca_pkg::CFG_HUE: gain_nxt.hue = cfg_data;
        hca_pkg::CFG_SAT: gain_nxt.sat = cfg_data;
        hca_pkg::CFG_VAL: gain_nxt.val = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      gain_r <= '{hue: 12'd256, sat: 12'd256, val: 12'd256};
    end else begin
      vld_r  <= vld_nxt;
      gain_r <= gain_nxt;
    end
  end

  hca_rgb2hsv u_fwd_a (
    .clk(clk), .en(en),
    .red(in_tdata[15:12]), .green(in_tdata[11:8]), .blue(in_tdata[7:4]),
    .gain(gain_r), .prod(prod_a)
  );

  hca_rgb2hsv u_fwd_b (
    .clk(clk), .en(en),
    .red(in_tdata[31:28]), .green(in_tdata[27:24]), .blue(in_tdata[23:20]),
    .gain(gain_r), .prod(prod_b)
  );

  hca_hsv2rgb u_bwd_a (
    .clk(clk), .en(en), .prod(prod_a),
    .red(red_a), .green(green_a), .blue(blue_a)
  );

  hca_hsv2rgb u_bwd_b (
    .clk(clk), .en(en), .prod(prod_b),
    .red(red_b), .green(green_b), .blue(blue_b)
  );

  assign out_tvalid = vld_r[hca_pkg::DEPTH-1];
  assign out_tdata  = {blue_b, green_b, red_b, blue_a, green_a, red_a};

endmodule

// ----- verif/hsv_color_adjust_tb.sv -----
module hsv_color_adjust_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0] blue_b;
    logic [3:0] green_b;
    logic [3:0] red_b;
    logic [3:0] blue_a;
    logic [3:0] green_a;
    logic [3:0] red_a;
  } pix_pair_t;

  class pixel_scoreboard;
    int unsigned hue_gain, sat_gain, val_gain;
    pix_pair_t   pending[$];
    int          errors;
    int unsigned checked;

    function void set_gains(int unsigned h, int unsigned s, int unsigned v);
      hue_gain = h;
      sat_gain = s;
      val_gain = v;
    endfunction

    function logic [3:0] nibble_of(longint unsigned x);
      longint unsigned c;
      c = (x * 15 + 64) >> 12;
      return (c > 15) ? 4'd15 : c[3:0];
    endfunction

    function longint unsigned clamp1(longint unsigned x);
      return (x > hca_pkg::ONE_Q12) ? hca_pkg::ONE_Q12 : x;
    endfunction

    function logic [11:0] adjust(logic [3:0] r, logic [3:0] g, logic [3:0] b);
      longint unsigned mx, mn, d, h, s, v, seg, rm, sf, p, q, t, cr, cg, cb;
      longint num;
      mx = (r > g) ? r : g;
      mn = (r < g) ? r : g;
      if (b > mx) mx = b;
      if (b < mn) mn = b;
      d = mx - mn;
      v = mx * hca_pkg::ONE_Q12 / 15;
      s = (mx != 0) ? d * hca_pkg::ONE_Q12 / mx : 0;
      h = 0;
      if (d != 0) begin
        if (mx == r) num = 92160 * longint'(d) + 15360 * (longint'(g) - longint'(b));
        else if (mx == g) num = 30720 * longint'(d) + 15360 * (longint'(b) - longint'(r));
        else num = 61440 * longint'(d) + 15360 * (longint'(r) - longint'(g));
        h = longint'(num) / d;
        if (h >= hca_pkg::HUE_FULL) h -= hca_pkg::HUE_FULL;
      end
      h = (h * hue_gain) >> 8;
      s = (s * sat_gain) >> 8;
      v = (v * val_gain) >> 8;
      s = clamp1(s);
      if (h > hca_pkg::HUE_FULL) h = hca_pkg::HUE_FULL;
      seg = h / hca_pkg::HUE_SEG;
      rm = h % hca_pkg::HUE_SEG;
      sf = s * rm / hca_pkg::HUE_SEG;
      p = clamp1((v * (hca_pkg::ONE_Q12 - s)) >> 12);
      q = clamp1((v * (hca_pkg::ONE_Q12 - sf)) >> 12);
      t = clamp1((v * (hca_pkg::ONE_Q12 - s + sf)) >> 12);
      case (seg)
        0: begin cr = v; cg = t; cb = p; end
        1: begin cr = q; cg = v; cb = p; end
        2: begin cr = p; cg = v; cb = t; end
        3: begin cr = p; cg = q; cb = v; end
        4: begin cr = t; cg = p; cb = v; end
        default: begin cr = v; cg = p; cb = q; end
      endcase
      return {nibble_of(cb), nibble_of(cg), nibble_of(cr)};
    endfunction

    function void note_input(logic [31:0] w);
      logic [11:0] a, bb;
      a  = adjust(w[15:12], w[11:8], w[7:4]);
      bb = adjust(w[31:28], w[27:24], w[23:20]);
      pending.push_back({bb, a});
    endfunction

    function void check_result(pix_pair_t got);
      pix_pair_t exp_px;
      if (pending.size() == 0) begin
        $error("result with nothing pending: %h", got);
        errors++;
        return;
      end
      exp_px = pending.pop_front();
      checked++;
      if (got.red_a !== exp_px.red_a) begin
        $error("red_a exp %0d got %0d", exp_px.red_a, got.red_a); errors++;
      end
      if (got.green_a !== exp_px.green_a) begin
        $error("green_a exp %0d got %0d", exp_px.green_a, got.green_a); errors++;
      end
      if (got.blue_a !== exp_px.blue_a) begin
        $error("blue_a exp %0d got %0d", exp_px.blue_a, got.blue_a); errors++;
      end
      if (got.red_b !== exp_px.red_b) begin
        $error("red_b exp %0d got %0d", exp_px.red_b, got.red_b); errors++;
      end
      if (got.green_b !== exp_px.green_b) begin
        $error("green_b exp %0d got %0d", exp_px.green_b, got.green_b); errors++;
      end
      if (got.blue_b !== exp_px.blue_b) begin
        $error("blue_b exp %0d got %0d", exp_px.blue_b, got.blue_b); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  pixel_scoreboard sb;
  int  send_idle_pct, recv_idle_pct;
  bit  hold_off;
  int  hold_cycles;
  longint unsigned cycles = 0;
  int unsigned words_sent;

  hsv_color_adjust dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: sample at rising edge, change ready at falling edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_gain(logic [1:0] idx, logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_gains(logic [11:0] h, logic [11:0] s, logic [11:0] v);
    write_gain(hca_pkg::CFG_HUE, h);
    write_gain(hca_pkg::CFG_SAT, s);
    write_gain(hca_pkg::CFG_VAL, v);
    cfg_valid <= 1'b0;
    sb.set_gains(h, s, v);
  endtask

  task automatic send_word(logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    w = $urandom();
    if ($urandom_range(3) == 0) begin
      w[15:12] = w[11:8];
      if ($urandom_range(1)) w[7:4] = w[11:8];
    end
    return w;
  endfunction

  initial begin
    logic [11:0] gains[6][3];
    sb = new();
    sb.set_gains(256, 256, 256);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: greys, primaries, extremes, hue at the wrap point
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h8880_7770);
    send_word(32'hF000_0F00);
    send_word(32'h00F0_F000);
    send_word(32'hFF00_0FF0);
    send_word(32'hF0F0_0FF0);
    send_word(32'hF010_F100);
    send_word(32'h1230_ABC0);
    send_word(32'h5A5A_A5A5);
    drain();
    set_gains(12'd4095, 12'd4095, 12'd4095);
    send_word(32'hF000_F010);
    send_word(32'hF0F0_8880);
    send_word(32'h3210_FED0);
    send_word(32'hFFFF_0000);
    drain();
    set_gains(12'd0, 12'd0, 12'd0);
    send_word(32'hF0F0_0F00);
    send_word(32'h9630_ABC0);
    drain();
    set_gains(12'd360, 12'd300, 12'd200);
    send_word(32'hF010_F100);
    send_word(32'hF000_0FF0);
    drain();

    gains = '{'{256, 256, 256}, '{4095, 128, 512}, '{0, 4095, 300},
              '{512, 256, 4095}, '{300, 0, 100}, '{256, 256, 256}};
    for (int ph = 0; ph < 6; ph++) begin
      set_gains(gains[ph][0], gains[ph][1], gains[ph][2]);
      if (ph < 2) begin send_idle_pct = 23; recv_idle_pct = 64; end
      else if (ph < 4) begin send_idle_pct = 64; recv_idle_pct = 23; end
      else begin send_idle_pct = 0; recv_idle_pct = 0; end
      if (ph == 4) hold_cycles = 60;
      for (int n = 0; n < 115; n++) send_word(rand_word());
      drain();
    end

    $display("covered %0d words, %0d results checked over 10 gain settings",
             words_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/hca_pkg.sv
rtl/hca_rgb2hsv.sv
rtl/hca_hsv2rgb.sv
rtl/hsv_color_adjust.sv
verif/hsv_color_adjust_tb.sv
